[sv/drwoc_pkg.sv]
// Package for the dual range classifier: payload types, register map and constants.
package drwoc_pkg;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_DETECT_DISTANCE   = 3'd0,
    REG_HEIGHT_DIFFERENCE = 3'd1,
    REG_WINDOW_LEFT       = 3'd2,
    REG_WINDOW_RIGHT      = 3'd3,
    REG_SWEEP_ENABLE      = 3'd4
  } reg_index_t;

  localparam int unsigned ADDR_W = 5;

  localparam logic [15:0]        FAULT_LIMIT     = 16'd65000;
  localparam logic [15:0]        FAULT_RANGE     = 16'hFFFF;
  localparam logic [12:0]        FRONT_ARC       = 13'd500;
  localparam logic [7:0]         FAULT_THRESHOLD = 8'd3;
  localparam logic [7:0]         COUNT_MAX       = 8'hFF;
  localparam logic signed [12:0] SWEEP_MARGIN    = 13'sd20;

  localparam logic [15:0]        RESET_DETECT_DISTANCE   = 16'd1000;
  localparam logic [15:0]        RESET_HEIGHT_DIFFERENCE = 16'd100;
  localparam logic signed [11:0] RESET_WINDOW_LEFT       = 12'sd600;
  localparam logic signed [11:0] RESET_WINDOW_RIGHT      = -12'sd600;

  typedef struct packed {
    logic [15:0]        top_raw;
    logic               top_timeout;
    logic [15:0]        bottom_raw;
    logic               bottom_timeout;
    logic signed [11:0] servo_angle;
    logic               clear_latched;
  } sample_t;

  typedef struct packed {
    logic [15:0]        top_range;
    logic [15:0]        bottom_range;
    logic               weight_found;
    logic [15:0]        weight_distance;
    logic signed [11:0] weight_angle;
    logic               obstacle_found;
    logic [15:0]        obstacle_distance;
    logic               sensor_fault;
    logic               sweep_right;
  } result_t;

  typedef struct packed {
    logic [15:0]        detect_distance;
    logic [15:0]        height_difference;
    logic signed [11:0] window_left;
    logic signed [11:0] window_right;
    logic               sweep_enable;
    logic               sweep_restart;
  } cfg_t;

endpackage

[sv/drwoc_regs.sv]
// Configuration register file behind the APB-style port.
module drwoc_regs import drwoc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [15:0]        detect_distance;
  logic [15:0]        height_difference;
  logic signed [11:0] window_left;
  logic signed [11:0] window_right;
  logic               sweep_enable;
  logic               sweep_restart;
  logic               wr;
  reg_index_t         idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_index_t'(paddr[ADDR_W-1:2]);

  // Flag a restart in the write cycle that switches sweeping on
  assign sweep_restart = wr && (idx == REG_SWEEP_ENABLE) && pwdata[0] && !sweep_enable;

  // Write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      detect_distance   <= RESET_DETECT_DISTANCE;
      height_difference <= RESET_HEIGHT_DIFFERENCE;
      window_left       <= RESET_WINDOW_LEFT;
      window_right      <= RESET_WINDOW_RIGHT;
      sweep_enable      <= 1'b0;
    end else begin
      if (wr) begin
        unique case (idx)
          REG_DETECT_DISTANCE:   detect_distance   <= pwdata[15:0];
          REG_HEIGHT_DIFFERENCE: height_difference <= pwdata[15:0];
          REG_WINDOW_LEFT:       window_left       <= pwdata[11:0];
          REG_WINDOW_RIGHT:      window_right      <= pwdata[11:0];
          REG_SWEEP_ENABLE:      sweep_enable      <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_DETECT_DISTANCE:   prdata = {16'd0, detect_distance};
      REG_HEIGHT_DIFFERENCE: prdata = {16'd0, height_difference};
      REG_WINDOW_LEFT:       prdata = {{20{window_left[11]}}, window_left};
      REG_WINDOW_RIGHT:      prdata = {{20{window_right[11]}}, window_right};
      REG_SWEEP_ENABLE:      prdata = {31'd0, sweep_enable};
      default:               prdata = 32'd0;
    endcase
  end

  assign cfg = '{detect_distance:   detect_distance,
                 height_difference: height_difference,
                 window_left:       window_left,
                 window_right:      window_right,
                 sweep_enable:      sweep_enable,
                 sweep_restart:     sweep_restart};

endmodule

[sv/drwoc_core.sv]
// Classification logic with fault counters, obstacle latch and sweep direction.
module drwoc_core import drwoc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  sample_t sample,
  input  cfg_t    cfg,
  output result_t result
);

  logic [7:0]         top_fault_count, top_fault_count_next;
  logic [7:0]         bottom_fault_count, bottom_fault_count_next;
  logic               obstacle_valid, obstacle_valid_next;
  logic [15:0]        obstacle_range, obstacle_range_next;
  logic               direction_right, direction_right_next;

  logic               top_bad, bot_bad;
  logic [15:0]        top, bot;
  logic signed [16:0] diff;
  logic [16:0]        adiff;
  logic signed [12:0] angle_x;
  logic [12:0]        aang;
  logic               weight_hit, obstacle_hit;
  logic               obs_found;
  logic [15:0]        obs_range;

  always_comb begin
    // Qualify both ranges and update fault counters
    top_bad = sample.top_timeout || (sample.top_raw > FAULT_LIMIT);
    bot_bad = sample.bottom_timeout || (sample.bottom_raw > FAULT_LIMIT);
    top     = top_bad ? FAULT_RANGE : sample.top_raw;
    bot     = bot_bad ? FAULT_RANGE : sample.bottom_raw;
    if (top_bad) begin
      top_fault_count_next = (top_fault_count == COUNT_MAX) ? top_fault_count
                                                            : top_fault_count + 8'd1;
    end else begin
      top_fault_count_next = 8'd0;
    end
    if (bot_bad) begin
      bottom_fault_count_next = (bottom_fault_count == COUNT_MAX) ? bottom_fault_count
                                                                  : bottom_fault_count + 8'd1;
    end else begin
      bottom_fault_count_next = 8'd0;
    end

    // Range difference and angle magnitude
    diff    = $signed({1'b0, top}) - $signed({1'b0, bot});
    adiff   = diff[16] ? 17'(-diff) : 17'(diff);
    angle_x = {sample.servo_angle[11], sample.servo_angle};
    aang    = angle_x[12] ? 13'(-angle_x) : 13'(angle_x);

    weight_hit = (sample.servo_angle < cfg.window_left) &&
                 (sample.servo_angle > cfg.window_right) &&
                 (bot < cfg.detect_distance) &&
                 (diff > $signed({1'b0, cfg.height_difference}));

    obstacle_hit = (top < cfg.detect_distance) &&
                   (adiff < {1'b0, cfg.height_difference}) &&
                   (aang < FRONT_ARC);

    // Latch obstacle, report, then drop on clear request
    obs_found = obstacle_hit || obstacle_valid;
    obs_range = obstacle_hit ? top : obstacle_range;
    if (sample.clear_latched) begin
      obstacle_valid_next = 1'b0;
      obstacle_range_next = 16'd0;
    end else begin
      obstacle_valid_next = obs_found;
      obstacle_range_next = obs_range;
    end

    // Sweep direction with margin at the window limits
    direction_right_next = direction_right;
    if (cfg.sweep_enable) begin
      if (direction_right) begin
        if (angle_x < $signed({cfg.window_right[11], cfg.window_right}) + SWEEP_MARGIN) begin
          direction_right_next = 1'b0;
        end
      end else begin
        if (angle_x > $signed({cfg.window_left[11], cfg.window_left}) - SWEEP_MARGIN) begin
          direction_right_next = 1'b1;
        end
      end
    end

    result.top_range         = top;
    result.bottom_range      = bot;
    result.weight_found      = weight_hit;
    result.weight_distance   = weight_hit ? bot : 16'd0;
    result.weight_angle      = weight_hit ? sample.servo_angle : 12'sd0;
    result.obstacle_found    = obs_found;
    result.obstacle_distance = obs_found ? obs_range : 16'd0;
    result.sensor_fault      = (top_fault_count_next > FAULT_THRESHOLD) ||
                               (bottom_fault_count_next > FAULT_THRESHOLD);
    result.sweep_right       = direction_right_next;
  end

  // Commit state when a beat moves to the result register, unless a sweep restart clears the direction
  always_ff @(posedge clk) begin
    if (rst) begin
      top_fault_count    <= 8'd0;
      bottom_fault_count <= 8'd0;
      obstacle_valid     <= 1'b0;
      obstacle_range     <= 16'd0;
      direction_right    <= 1'b0;
    end else if (cfg.sweep_restart) begin
      direction_right    <= 1'b0;
    end else if (fire) begin
      top_fault_count    <= top_fault_count_next;
      bottom_fault_count <= bottom_fault_count_next;
      obstacle_valid     <= obstacle_valid_next;
      obstacle_range     <= obstacle_range_next;
      direction_right    <= direction_right_next;
    end
  end

endmodule

[sv/dual_range_weight_obstacle_classifier.sv]
// Top level of the dual range weight and obstacle classifier.
// An accepted sample beat passes through the input register, then the result
// register, on its way to its result beat.
// Throughput: one sample per cycle unless result_stall holds the result register.
// Reset (rst, synchronous): empties both stages, clears fault counters, obstacle
// latch and direction, and loads the register defaults.
module dual_range_weight_obstacle_classifier import drwoc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  sample_t           sample,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t    cfg;
  sample_t stage;
  logic    stage_valid;
  logic    advance;
  logic    fire;
  result_t core_result;

  drwoc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  drwoc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .sample (stage),
    .cfg    (cfg),
    .result (core_result)
  );

  assign advance      = !result_valid || !result_stall;
  assign fire         = advance && stage_valid;
  assign sample_stall = stage_valid && !advance;

  // Advance the two stages
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (!sample_stall) begin
        stage_valid <= sample_valid;
      end
      if (advance) begin
        result_valid <= stage_valid;
      end
    end
  end

  // Hold payloads while stalled
  always_ff @(posedge clk) begin
    if (!sample_stall && sample_valid) begin
      stage <= sample;
    end
    if (fire) begin
      result <= core_result;
    end
  end

endmodule

[sv/drwoc_checker.sv]
// Port checker for the classifier, bound to the top level.
module drwoc_checker import drwoc_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // Hold a stalled result beat
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  // Empty the pipeline on reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // No weight means zero distance and angle
  a_no_weight: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.weight_found |->
      result.weight_distance == 16'd0 && result.weight_angle == 12'sd0)
    else $error("weight fields set without a weight");

  // No obstacle means zero distance
  a_no_obstacle: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.obstacle_found |-> result.obstacle_distance == 16'd0)
    else $error("obstacle distance set without an obstacle");

  // A faulted top range reads as the fault code
  a_fault_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.top_range > FAULT_LIMIT |-> result.top_range == FAULT_RANGE)
    else $error("top range above limit but not the fault code");

endmodule

bind dual_range_weight_obstacle_classifier drwoc_checker u_drwoc_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

[tb/dual_range_weight_obstacle_classifier_tb.sv]
// Self-checking testbench for the dual range weight and obstacle classifier.
module dual_range_weight_obstacle_classifier_tb;
  import drwoc_pkg::*;

  typedef struct packed {
    sample_t beat;
    logic    typed;
    result_t want;
  } directed_row_t;

  logic              clk;
  logic              rst;
  logic              sample_valid;
  logic              sample_stall;
  sample_t           sample;
  logic              result_valid;
  logic              result_stall;
  result_t           result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // Shadow of the register bank
  logic [15:0]        cfg_detect;
  logic [15:0]        cfg_height;
  logic signed [11:0] cfg_left;
  logic signed [11:0] cfg_right;
  logic               cfg_sweep;

  // Classifier state as the predictor sees it
  int          top_faults;
  int          bottom_faults;
  logic        obstacle_held;
  logic [15:0] obstacle_mm;
  logic        heading_right;

  result_t       expected_results[$];
  directed_row_t base_rows[$];
  directed_row_t sweep_rows[$];
  int            mismatch_count;
  int            results_seen;
  int            sweep_pos;
  int            top_dead;
  int            bottom_dead;
  bit            sender_calm;
  bit            receiver_calm;
  bit            hold_request;

  dual_range_weight_obstacle_classifier dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Bound the run
  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    if (mismatch_count < 100) begin
      $display("mismatch on %s at result beat %0d: got %0d, expected %0d",
               what, results_seen, got_v, want_v);
    end
    mismatch_count++;
  endtask

  // Qualify one range reading and update that sensor's fault counter
  function automatic logic [15:0] qualify_range(input logic [15:0] raw, input logic timed_out,
                                                inout int faults);
    if (timed_out || raw > FAULT_LIMIT) begin
      if (faults < int'(COUNT_MAX)) faults++;
      return FAULT_RANGE;
    end
    faults = 0;
    return raw;
  endfunction

  // Work out the result beat for one sample and advance the classifier state
  function automatic result_t classify_sample(input sample_t s);
    result_t     r;
    logic [15:0] top;
    logic [15:0] bot;
    int          ang;
    int          diff;
    int          adiff;
    int          aang;
    top   = qualify_range(s.top_raw, s.top_timeout, top_faults);
    bot   = qualify_range(s.bottom_raw, s.bottom_timeout, bottom_faults);
    ang   = int'(s.servo_angle);
    diff  = int'(top) - int'(bot);
    adiff = diff < 0 ? -diff : diff;
    aang  = ang < 0 ? -ang : ang;
    r     = '0;
    r.top_range    = top;
    r.bottom_range = bot;
    if (ang < int'(cfg_left) && ang > int'(cfg_right) && bot < cfg_detect &&
        diff > int'(cfg_height)) begin
      r.weight_found    = 1'b1;
      r.weight_distance = bot;
      r.weight_angle    = s.servo_angle;
    end
    if (top < cfg_detect && adiff < int'(cfg_height) && aang < int'(FRONT_ARC)) begin
      obstacle_held = 1'b1;
      obstacle_mm   = top;
    end
    // Flip the sweep near the window limits
    if (cfg_sweep) begin
      if (heading_right) begin
        if (ang < int'(cfg_right) + int'(SWEEP_MARGIN)) heading_right = 1'b0;
      end else begin
        if (ang > int'(cfg_left) - int'(SWEEP_MARGIN)) heading_right = 1'b1;
      end
    end
    r.obstacle_found    = obstacle_held;
    r.obstacle_distance = obstacle_held ? obstacle_mm : 16'd0;
    r.sensor_fault      = top_faults > int'(FAULT_THRESHOLD) ||
                          bottom_faults > int'(FAULT_THRESHOLD);
    r.sweep_right       = heading_right;
    if (s.clear_latched) begin
      obstacle_held = 1'b0;
      obstacle_mm   = '0;
    end
    return r;
  endfunction

  function automatic logic [15:0] clamp_mm(input int v);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  function automatic logic signed [11:0] clamp_angle(input int a);
    if (a > 1800) a = 1800;
    if (a < -1800) a = -1800;
    return a[11:0];
  endfunction

  function automatic sample_t mk_sample(input int top, input bit tt, input int bot,
                                        input bit bt, input int ang, input bit clr);
    sample_t s;
    s.top_raw        = top[15:0];
    s.top_timeout    = tt;
    s.bottom_raw     = bot[15:0];
    s.bottom_timeout = bt;
    s.servo_angle    = ang[11:0];
    s.clear_latched  = clr;
    return s;
  endfunction

  function automatic result_t mk_result(input int top, input int bot, input bit wf,
                                        input int wd, input int wa, input bit of,
                                        input int od, input bit sf, input bit sr);
    result_t r;
    r.top_range         = top[15:0];
    r.bottom_range      = bot[15:0];
    r.weight_found      = wf;
    r.weight_distance   = wd[15:0];
    r.weight_angle      = wa[11:0];
    r.obstacle_found    = of;
    r.obstacle_distance = od[15:0];
    r.sensor_fault      = sf;
    r.sweep_right       = sr;
    return r;
  endfunction

  // Range up to the detection threshold, edge included
  function automatic int near_below(input int d);
    if (d <= 0) return int'($urandom_range(0, 30));
    return int'($urandom_range(0, d));
  endfunction

  function automatic int edge_mm(input int d);
    case ($urandom_range(0, 6))
      0:       return 0;
      1:       return int'(FAULT_LIMIT);
      2:       return int'(FAULT_LIMIT) + 1;
      3:       return 65535;
      4:       return d - 1;
      5:       return d;
      default: return d + 1;
    endcase
  endfunction

  // Draw one sample, biased towards detections, window edges and fault runs
  function automatic sample_t next_random_sample();
    sample_t s;
    int      top_mm;
    int      bot_mm;
    int      ang;
    int      d;
    int      h;
    d = cfg_detect;
    h = cfg_height;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        top_mm = near_below(d);
        bot_mm = top_mm + int'($urandom_range(0, h + 20)) - (h + 20) / 2;
      end
      3, 4, 5: begin
        bot_mm = near_below(d);
        top_mm = bot_mm + h + int'($urandom_range(0, 40)) - 20;
      end
      6: begin
        top_mm = edge_mm(d);
        bot_mm = edge_mm(d);
      end
      default: begin
        top_mm = int'($urandom_range(0, 65535));
        bot_mm = int'($urandom_range(0, 65535));
      end
    endcase
    s.top_raw        = clamp_mm(top_mm);
    s.bottom_raw     = clamp_mm(bot_mm);
    s.top_timeout    = ($urandom_range(0, 11) == 0);
    s.bottom_timeout = ($urandom_range(0, 11) == 0);
    // Hold a sensor dead for a run so its counter climbs and saturates
    if (top_dead > 0) begin
      top_dead--;
      if ($urandom_range(0, 1)) s.top_timeout = 1'b1;
      else s.top_raw = 16'($urandom_range(65001, 65535));
    end else if ($urandom_range(0, 149) == 0) begin
      top_dead = $urandom_range(4, 300);
    end
    if (bottom_dead > 0) begin
      bottom_dead--;
      if ($urandom_range(0, 1)) s.bottom_timeout = 1'b1;
      else s.bottom_raw = 16'($urandom_range(65001, 65535));
    end else if ($urandom_range(0, 149) == 0) begin
      bottom_dead = $urandom_range(4, 300);
    end
    // Follow the sweep most of the time, else jump or sit on an edge
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        sweep_pos = sweep_pos + (heading_right ? -1 : 1) * int'($urandom_range(5, 60));
        if (sweep_pos > 1800) sweep_pos = 1800;
        if (sweep_pos < -1800) sweep_pos = -1800;
        ang = sweep_pos;
      end
      6, 7: ang = int'($urandom_range(0, 3600)) - 1800;
      default: begin
        case ($urandom_range(0, 9))
          0:       ang = int'(cfg_left);
          1:       ang = int'(cfg_left) - 1;
          2:       ang = int'(cfg_left) - int'(SWEEP_MARGIN);
          3:       ang = int'(cfg_left) - int'(SWEEP_MARGIN) - 1;
          4:       ang = int'(cfg_right);
          5:       ang = int'(cfg_right) + 1;
          6:       ang = int'(cfg_right) + int'(SWEEP_MARGIN);
          7:       ang = int'(cfg_right) + int'(SWEEP_MARGIN) - 1;
          8:       ang = $urandom_range(0, 1) ? int'(FRONT_ARC) : -int'(FRONT_ARC);
          default: ang = $urandom_range(0, 1) ? int'(FRONT_ARC) - 1 : 1 - int'(FRONT_ARC);
        endcase
      end
    endcase
    s.servo_angle   = clamp_angle(ang);
    s.clear_latched = ($urandom_range(0, 7) == 0);
    return s;
  endfunction

  // Offer one sample beat after a random gap unless sender_calm is set, and log its expected result on acceptance
  task automatic push_sample(input sample_t s, input logic typed, input result_t want);
    int      gap;
    int      r;
    result_t predicted;
    gap = 0;
    if (!sender_calm) begin
      r = $urandom_range(0, 99);
      if (r >= 90) gap = $urandom_range(8, 30);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (sample_stall);
    predicted = classify_sample(s);
    expected_results.push_back(typed ? want : predicted);
  endtask

  task automatic play_rows(input directed_row_t rows[$]);
    foreach (rows[i]) push_sample(rows[i].beat, rows[i].typed, rows[i].want);
  endtask

  task automatic send_random_samples(input int count);
    repeat (count) push_sample(next_random_sample(), 1'b0, result_t'('0));
  endtask

  // Stop offering and wait until every expected beat has come back
  task automatic drain_results();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register, mirror it in the shadow, then read it back
  task automatic write_register(input reg_index_t idx, input logic [31:0] value);
    logic [31:0] mask;
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DETECT_DISTANCE: begin
        cfg_detect = value[15:0];
        mask       = 32'hFFFF;
      end
      REG_HEIGHT_DIFFERENCE: begin
        cfg_height = value[15:0];
        mask       = 32'hFFFF;
      end
      REG_WINDOW_LEFT: begin
        cfg_left = value[11:0];
        mask     = 32'hFFF;
      end
      REG_WINDOW_RIGHT: begin
        cfg_right = value[11:0];
        mask      = 32'hFFF;
      end
      default: begin
        if (value[0] && !cfg_sweep) heading_right = 1'b0;
        cfg_sweep = value[0];
        mask      = 32'h1;
      end
    endcase
    // Back-to-back read of the same register
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((readback & mask) !== (value & mask)) begin
      report_mismatch({"readback of ", idx.name()}, int'(readback & mask), int'(value & mask));
    end
    // Pass through the idle state before the next transfer
    @(posedge clk);
  endtask

  // Result side: check accepted beats and stall in bursts
  initial begin : result_sink
    int stall_run;
    int free_run;
    int r;
    result_t want;
    result_stall = 1'b0;
    stall_run    = 0;
    free_run     = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing expected, top_range",
                          int'(result.top_range), 0);
        end else begin
          want = expected_results.pop_front();
          if (result.top_range !== want.top_range)
            report_mismatch("top_range", result.top_range, want.top_range);
          if (result.bottom_range !== want.bottom_range)
            report_mismatch("bottom_range", result.bottom_range, want.bottom_range);
          if (result.weight_found !== want.weight_found)
            report_mismatch("weight_found", result.weight_found, want.weight_found);
          if (result.weight_distance !== want.weight_distance)
            report_mismatch("weight_distance", result.weight_distance, want.weight_distance);
          if (result.weight_angle !== want.weight_angle)
            report_mismatch("weight_angle", result.weight_angle, want.weight_angle);
          if (result.obstacle_found !== want.obstacle_found)
            report_mismatch("obstacle_found", result.obstacle_found, want.obstacle_found);
          if (result.obstacle_distance !== want.obstacle_distance)
            report_mismatch("obstacle_distance", result.obstacle_distance,
                            want.obstacle_distance);
          if (result.sensor_fault !== want.sensor_fault)
            report_mismatch("sensor_fault", result.sensor_fault, want.sensor_fault);
          if (result.sweep_right !== want.sweep_right)
            report_mismatch("sweep_right", result.sweep_right, want.sweep_right);
        end
        results_seen++;
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall_run    = 120;
      end
      if (stall_run > 0) begin
        stall_run--;
        result_stall <= 1'b1;
      end else if (free_run > 0 || receiver_calm) begin
        if (free_run > 0) free_run--;
        result_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          free_run = $urandom_range(0, 10);
          result_stall <= 1'b0;
        end else if (r < 93) begin
          stall_run = $urandom_range(0, 2);
          result_stall <= 1'b1;
        end else begin
          stall_run = $urandom_range(10, 40);
          result_stall <= 1'b1;
        end
      end
    end
  end

  // Sample side: reset, directed tables, then random phases under several settings
  initial begin : sample_source
    rst            = 1'b1;
    sample_valid   = 1'b0;
    sample         = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    cfg_detect     = RESET_DETECT_DISTANCE;
    cfg_height     = RESET_HEIGHT_DIFFERENCE;
    cfg_left       = RESET_WINDOW_LEFT;
    cfg_right      = RESET_WINDOW_RIGHT;
    cfg_sweep      = 1'b0;
    top_faults     = 0;
    bottom_faults  = 0;
    obstacle_held  = 1'b0;
    obstacle_mm    = '0;
    heading_right  = 1'b0;
    mismatch_count = 0;
    results_seen   = 0;
    sweep_pos      = 0;
    top_dead       = 0;
    bottom_dead    = 0;
    sender_calm    = 1'b0;
    receiver_calm  = 1'b0;
    hold_request   = 1'b0;

    // Defaults after reset: all-zero pair latches and clears
    base_rows.push_back(directed_row_t'({mk_sample(0, 0, 0, 0, 0, 1), 1'b1,
                        mk_result(0, 0, 0, 0, 0, 1, 0, 0, 0)}));
    // Both sensors time out at the top of every field
    base_rows.push_back(directed_row_t'({mk_sample(65535, 1, 65535, 1, 1800, 0), 1'b1,
                        mk_result(65535, 65535, 0, 0, 0, 0, 0, 0, 0)}));
    // Just over the fault limit on top, exactly on it below
    base_rows.push_back(directed_row_t'({mk_sample(65001, 0, 65000, 0, -1800, 0), 1'b1,
                        mk_result(65535, 65000, 0, 0, 0, 0, 0, 0, 0)}));
    // Faulted top over a close bottom reads as a weight; fourth fault raises the flag
    base_rows.push_back(directed_row_t'({mk_sample(100, 1, 5, 0, 0, 0), 1'b1,
                        mk_result(65535, 5, 1, 5, 0, 0, 0, 0, 0)}));
    base_rows.push_back(directed_row_t'({mk_sample(100, 1, 5, 0, 599, 0), 1'b1,
                        mk_result(65535, 5, 1, 5, 599, 0, 0, 1, 0)}));
    // Good top clears the counter and latches an obstacle
    base_rows.push_back(directed_row_t'({mk_sample(500, 0, 450, 0, -499, 0), 1'b1,
                        mk_result(500, 450, 0, 0, 0, 1, 500, 0, 0)}));
    base_rows.push_back(directed_row_t'({mk_sample(65000, 0, 65000, 0, 500, 1), 1'b1,
                        mk_result(65000, 65000, 0, 0, 0, 1, 500, 0, 0)}));
    // Window and difference boundaries
    base_rows.push_back(directed_row_t'({mk_sample(0, 1, 0, 1, 600, 0), 1'b0, result_t'('0)}));
    base_rows.push_back(directed_row_t'({mk_sample(1100, 0, 999, 0, -600, 0), 1'b0,
                        result_t'('0)}));
    base_rows.push_back(directed_row_t'({mk_sample(1100, 0, 999, 0, -599, 0), 1'b0,
                        result_t'('0)}));
    base_rows.push_back(directed_row_t'({mk_sample(1099, 0, 999, 0, -599, 0), 1'b0,
                        result_t'('0)}));
    // Obstacle arc edges, clear after report, and detect-and-clear in one beat
    base_rows.push_back(directed_row_t'({mk_sample(999, 0, 900, 0, 499, 0), 1'b0,
                        result_t'('0)}));
    base_rows.push_back(directed_row_t'({mk_sample(999, 0, 1098, 0, -500, 1), 1'b0,
                        result_t'('0)}));
    base_rows.push_back(directed_row_t'({mk_sample(900, 0, 999, 0, 0, 1), 1'b0,
                        result_t'('0)}));
    base_rows.push_back(directed_row_t'({mk_sample(1000, 0, 1000, 0, 0, 0), 1'b0,
                        result_t'('0)}));
    base_rows.push_back(directed_row_t'({mk_sample(65535, 0, 0, 1, 0, 0), 1'b0,
                        result_t'('0)}));
    base_rows.push_back(directed_row_t'({mk_sample(0, 0, 65535, 0, -1, 0), 1'b0,
                        result_t'('0)}));

    // Sweep turn points with the default window
    sweep_rows.push_back(directed_row_t'({mk_sample(2000, 0, 2000, 0, 580, 0), 1'b0,
                         result_t'('0)}));
    sweep_rows.push_back(directed_row_t'({mk_sample(2000, 0, 2000, 0, 581, 0), 1'b0,
                         result_t'('0)}));
    sweep_rows.push_back(directed_row_t'({mk_sample(2000, 0, 2000, 0, -580, 0), 1'b0,
                         result_t'('0)}));
    sweep_rows.push_back(directed_row_t'({mk_sample(2000, 0, 2000, 0, -581, 0), 1'b0,
                         result_t'('0)}));
    sweep_rows.push_back(directed_row_t'({mk_sample(2000, 0, 2000, 0, 1800, 0), 1'b0,
                         result_t'('0)}));
    sweep_rows.push_back(directed_row_t'({mk_sample(2000, 0, 2000, 0, -1800, 1), 1'b0,
                         result_t'('0)}));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Centred mode on reset settings
    play_rows(base_rows);
    send_random_samples(250);
    drain_results();

    // Sweep on; flood the block while the result side holds off
    write_register(REG_SWEEP_ENABLE, 32'd1);
    play_rows(sweep_rows);
    sender_calm  = 1'b1;
    hold_request = 1'b1;
    send_random_samples(150);
    sender_calm = 1'b0;
    send_random_samples(150);
    drain_results();

    // Widest settings; sweep rewritten while already on
    write_register(REG_DETECT_DISTANCE, 32'd65535);
    write_register(REG_HEIGHT_DIFFERENCE, 32'd0);
    write_register(REG_WINDOW_LEFT, 32'(1800));
    write_register(REG_WINDOW_RIGHT, 32'(-1800));
    write_register(REG_SWEEP_ENABLE, 32'd1);
    sender_calm   = 1'b1;
    receiver_calm = 1'b1;
    send_random_samples(100);
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    send_random_samples(200);
    drain_results();

    // Nothing detectable, inverted window, sweep off; pause midway until empty
    write_register(REG_DETECT_DISTANCE, 32'd0);
    write_register(REG_HEIGHT_DIFFERENCE, 32'd65535);
    write_register(REG_WINDOW_LEFT, 32'(-1800));
    write_register(REG_WINDOW_RIGHT, 32'(1800));
    write_register(REG_SWEEP_ENABLE, 32'd0);
    send_random_samples(150);
    drain_results();
    send_random_samples(150);
    drain_results();

    // Raw register codes outside the angle range; re-enable restarts the sweep
    write_register(REG_DETECT_DISTANCE, 32'd2000);
    write_register(REG_HEIGHT_DIFFERENCE, 32'd300);
    write_register(REG_WINDOW_LEFT, 32'h7FF);
    write_register(REG_WINDOW_RIGHT, 32'h800);
    write_register(REG_SWEEP_ENABLE, 32'd1);
    send_random_samples(250);
    drain_results();

    // Random settings
    write_register(REG_DETECT_DISTANCE, 32'($urandom_range(0, 3000)));
    write_register(REG_HEIGHT_DIFFERENCE, 32'($urandom_range(0, 800)));
    write_register(REG_WINDOW_LEFT, 32'(int'($urandom_range(0, 3600)) - 1800));
    write_register(REG_WINDOW_RIGHT, 32'(int'($urandom_range(0, 3600)) - 1800));
    write_register(REG_SWEEP_ENABLE, 32'($urandom_range(0, 1)));
    send_random_samples(250);
    drain_results();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[dual_range_weight_obstacle_classifier.f]
sv/drwoc_pkg.sv
sv/drwoc_regs.sv
sv/drwoc_core.sv
sv/dual_range_weight_obstacle_classifier.sv
sv/drwoc_checker.sv
tb/dual_range_weight_obstacle_classifier_tb.sv
